// ----- rtl/rwc_pkg.sv -----
// Shared types and constants for the RSSI weighted centroid block.
// Used by rwc_ctrl, rwc_datapath and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rwc_pkg;

    // Widths sized for the largest supported window (8) and report limit (64)
    localparam int CNT_W  = 4;   // window fill count, 0..8
    localparam int PTR_W  = 3;   // window slot index, 0..7
    localparam int SUM_W  = 11;  // sum of up to 8 signed bytes
    localparam int RC_W   = 7;   // reports in one set, 0..64
    localparam int C2_W   = 7;   // count squared, up to 64
    localparam int DEN_W  = 22;  // sum squared
    localparam int W_W    = 32;  // weight, unsigned 0.32
    localparam int WT_W   = 40;  // weight total
    localparam int WX_W   = 48;  // weighted coordinate total
    localparam int PROD_W = 41;  // weight times coordinate
    localparam int Q_W    = 8;   // coordinate quotient
    localparam int STEP_W = 6;   // divider step counter
    localparam int SLOTS  = 4;
    localparam int WMAX   = 8;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] REG_ANCHOR0_X = 3'd0;
    localparam logic [ADDR_W-1:0] REG_ANCHOR0_Y = 3'd1;
    localparam logic [ADDR_W-1:0] REG_ANCHOR1_X = 3'd2;
    localparam logic [ADDR_W-1:0] REG_ANCHOR1_Y = 3'd3;
    localparam logic [ADDR_W-1:0] REG_ANCHOR2_X = 3'd4;
    localparam logic [ADDR_W-1:0] REG_ANCHOR2_Y = 3'd5;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PUSH,
        ST_SQUARE,
        ST_DINIT,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_CLOSE,
        ST_FX_INIT,
        ST_FX_DIV,
        ST_FY_INIT,
        ST_FY_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic latch;
        logic push;
        logic square;
        logic div_init;
        logic div_step;
        logic mul;
        logic acc;
        logic fin_init;
        logic fin_y;
        logic fin_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic item_ok;
        logic item_last;
        logic wt_zero;
        logic iter_done;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// ----- rtl/rssi_weighted_centroid_top.sv -----
// RSSI weighted centroid top level: controller plus datapath.
// Depends on rwc_pkg, rwc_ctrl and rwc_datapath.
//
// Usage:
//   s_* takes one RSSI report per word: tdata[1:0] anchor id, tdata[9:2]
//   RSSI in dBm (signed), tlast closes the set. m_* returns one word per
//   closed set: tdata[7:0] x, tdata[15:8] y (signed, truncated toward
//   zero), tuser status (0 ok, 1 invalid anchor seen, 2 empty set).
//   Anchor coordinates are written on cfg_we/cfg_addr/cfg_wdata while idle.
// Sequencing:
//   One report is in flight at a time. A valid report holds s_tready low
//   after acceptance while it passes the 32-step serial weight divider,
//   which is skipped when the weight saturates; an ignored report skips
//   the divider too. A closing report then runs two 8-step coordinate
//   divisions and loads the output (an empty set goes straight to the load).
// Reset: all windows, set totals and the output valid flag clear; anchor
//   coordinates return to their defaults.
// Stall: a finished result sits in the output register; the next report is
//   accepted meanwhile, and the block holds only when a new result is ready
//   before the previous one has been taken.
`timescale 1ns / 1ps
`default_nettype none
module rssi_weighted_centroid_top #(
    parameter int NUM_ANCHORS = 3,
    parameter int WINDOW      = 5,
    parameter int MAX_REPORTS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [1:0] anchor_id, [9:2] rssi_dbm, rest zero
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] pos_x, [15:8] pos_y
    output logic [1:0]       m_tuser    // [1:0] status
);

    rwc_pkg::cmd_t  cmd;
    rwc_pkg::stat_t stat;

    rwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rwc_datapath #(
        .NUM_ANCHORS (NUM_ANCHORS),
        .WINDOW      (WINDOW),
        .MAX_REPORTS (MAX_REPORTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_anchor_id (s_tdata[1:0]),
        .in_rssi_dbm  (s_tdata[9:2]),
        .in_last      (s_tlast),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_pos_x    (m_tdata[7:0]),
        .out_pos_y    (m_tdata[15:8]),
        .out_status   (m_tuser)
    );

endmodule
`default_nettype wire

// ----- rtl/rwc_ctrl.sv -----
// Sequencer for the RSSI weighted centroid block.
// Depends on rwc_pkg; drives rwc_datapath through cmd_t, reads stat_t.
`timescale 1ns / 1ps
`default_nettype none
module rwc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire rwc_pkg::stat_t stat,
    output rwc_pkg::cmd_t      cmd
);

    rwc_pkg::state_t state_reg;
    rwc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rwc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rwc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = rwc_pkg::ST_DECIDE;
                end
            end
            rwc_pkg::ST_DECIDE:
            begin
                state_next = stat.item_ok ? rwc_pkg::ST_PUSH : rwc_pkg::ST_CLOSE;
            end
            rwc_pkg::ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = rwc_pkg::ST_SQUARE;
            end
            rwc_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = rwc_pkg::ST_DINIT;
            end
            rwc_pkg::ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = rwc_pkg::ST_DIV;
            end
            rwc_pkg::ST_DIV:
            begin
                if (stat.iter_done)
                begin
                    state_next = rwc_pkg::ST_MUL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            rwc_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = rwc_pkg::ST_ACC;
            end
            rwc_pkg::ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = rwc_pkg::ST_CLOSE;
            end
            rwc_pkg::ST_CLOSE:
            begin
                if (!stat.item_last)
                begin
                    state_next = rwc_pkg::ST_IDLE;
                end
                else if (stat.wt_zero)
                begin
                    state_next = rwc_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = rwc_pkg::ST_FX_INIT;
                end
            end
            rwc_pkg::ST_FX_INIT:
            begin
                cmd.fin_init = 1'b1;
                state_next   = rwc_pkg::ST_FX_DIV;
            end
            rwc_pkg::ST_FX_DIV:
            begin
                if (stat.iter_done)
                begin
                    state_next = rwc_pkg::ST_FY_INIT;
                end
                else
                begin
                    cmd.fin_step = 1'b1;
                end
            end
            rwc_pkg::ST_FY_INIT:
            begin
                // Also captures the finished x quotient
                cmd.fin_init = 1'b1;
                cmd.fin_y    = 1'b1;
                state_next   = rwc_pkg::ST_FY_DIV;
            end
            rwc_pkg::ST_FY_DIV:
            begin
                if (stat.iter_done)
                begin
                    state_next = rwc_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.fin_step = 1'b1;
                end
            end
            rwc_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = rwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rwc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/rwc_datapath.sv -----
// Datapath: anchor windows, weight divider, accumulators, final divider
// and output register. Depends on rwc_pkg; commanded by rwc_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module rwc_datapath #(
    parameter int NUM_ANCHORS = 3,
    parameter int WINDOW      = 5,
    parameter int MAX_REPORTS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [rwc_pkg::ADDR_W-1:0]  cfg_addr,
    input  wire logic [7:0]                  cfg_wdata,
    input  wire logic [1:0]                  in_anchor_id,
    input  wire logic [7:0]                  in_rssi_dbm,
    input  wire logic                        in_last,
    input  wire rwc_pkg::cmd_t               cmd,
    output rwc_pkg::stat_t                   stat,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       out_pos_x,
    output logic [7:0]                       out_pos_y,
    output logic [1:0]                       out_status
);

    localparam int CNT_W  = rwc_pkg::CNT_W;
    localparam int PTR_W  = rwc_pkg::PTR_W;
    localparam int SUM_W  = rwc_pkg::SUM_W;
    localparam int RC_W   = rwc_pkg::RC_W;
    localparam int C2_W   = rwc_pkg::C2_W;
    localparam int DEN_W  = rwc_pkg::DEN_W;
    localparam int W_W    = rwc_pkg::W_W;
    localparam int WT_W   = rwc_pkg::WT_W;
    localparam int WX_W   = rwc_pkg::WX_W;
    localparam int PROD_W = rwc_pkg::PROD_W;
    localparam int Q_W    = rwc_pkg::Q_W;
    localparam int STEP_W = rwc_pkg::STEP_W;

    // Anchor coordinates
    logic signed [7:0] cx_reg [3];
    logic signed [7:0] cy_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg[0] <= 8'sd0;
            cy_reg[0] <= 8'sd0;
            cx_reg[1] <= 8'sd8;
            cy_reg[1] <= 8'sd0;
            cx_reg[2] <= 8'sd4;
            cy_reg[2] <= 8'sd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rwc_pkg::REG_ANCHOR0_X: cx_reg[0] <= cfg_wdata;
                rwc_pkg::REG_ANCHOR0_Y: cy_reg[0] <= cfg_wdata;
                rwc_pkg::REG_ANCHOR1_X: cx_reg[1] <= cfg_wdata;
                rwc_pkg::REG_ANCHOR1_Y: cy_reg[1] <= cfg_wdata;
                rwc_pkg::REG_ANCHOR2_X: cx_reg[2] <= cfg_wdata;
                rwc_pkg::REG_ANCHOR2_Y: cy_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input word
    logic [1:0]        aid_reg;
    logic signed [7:0] rssi_reg;
    logic              last_reg;
    logic              ok_reg;
    logic              invalid_reg;
    logic [RC_W-1:0]   rc_reg;
    logic              aid_in_range;

    assign aid_in_range = ({1'b0, in_anchor_id} < 3'(NUM_ANCHORS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aid_reg  <= '0;
            rssi_reg <= '0;
            last_reg <= 1'b0;
            ok_reg   <= 1'b0;
        end
        else if (cmd.latch)
        begin
            aid_reg  <= in_anchor_id;
            rssi_reg <= in_rssi_dbm;
            last_reg <= in_last;
            ok_reg   <= aid_in_range && (rc_reg < RC_W'(MAX_REPORTS));
        end
    end

    // Anchor windows
    logic signed [7:0]       win_reg [rwc_pkg::SLOTS][rwc_pkg::WMAX];
    logic [CNT_W-1:0]        cnt_reg [rwc_pkg::SLOTS];
    logic [PTR_W-1:0]        ptr_reg [rwc_pkg::SLOTS];
    logic signed [SUM_W-1:0] sum_reg [rwc_pkg::SLOTS];
    logic signed [SUM_W-1:0] s_reg;
    logic [CNT_W-1:0]        c_reg;

    logic [PTR_W-1:0]        p_cur;
    logic [PTR_W:0]          p_inc;
    logic [PTR_W-1:0]        p_next;
    logic                    win_full;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] new_sum;
    logic [CNT_W-1:0]        new_cnt;

    always_comb
    begin
        p_cur    = ({1'b0, ptr_reg[aid_reg]} >= 4'(WINDOW)) ? '0 : ptr_reg[aid_reg];
        p_inc    = {1'b0, p_cur} + 4'd1;
        p_next   = (p_inc >= 4'(WINDOW)) ? '0 : p_inc[PTR_W-1:0];
        win_full = (cnt_reg[aid_reg] >= CNT_W'(WINDOW));
        old_ext  = win_full ? SUM_W'(win_reg[aid_reg][p_cur]) : '0;
        new_sum  = sum_reg[aid_reg] - old_ext + SUM_W'(rssi_reg);
        new_cnt  = win_full ? cnt_reg[aid_reg] : cnt_reg[aid_reg] + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            win_reg[aid_reg][p_cur] <= rssi_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rwc_pkg::SLOTS; i++)
            begin
                cnt_reg[i] <= '0;
                ptr_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
            s_reg <= '0;
            c_reg <= '0;
        end
        else if (cmd.push)
        begin
            cnt_reg[aid_reg] <= new_cnt;
            ptr_reg[aid_reg] <= p_next;
            sum_reg[aid_reg] <= new_sum;
            s_reg            <= new_sum;
            c_reg            <= new_cnt;
        end
    end

    // Squares
    logic [DEN_W-1:0]        den_reg;
    logic [C2_W-1:0]         c2_reg;
    logic signed [DEN_W-1:0] s_wide;
    logic signed [DEN_W-1:0] s_sq;
    logic [2*CNT_W-1:0]      c_sq;

    assign s_wide = DEN_W'(s_reg);
    assign s_sq   = s_wide * s_wide;
    assign c_sq   = {{CNT_W{1'b0}}, c_reg} * {{CNT_W{1'b0}}, c_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            den_reg <= s_sq;
            c2_reg  <= c_sq[C2_W-1:0];
        end
    end

    // Shared step counter for both dividers
    logic [STEP_W-1:0] step_reg;

    // Weight divider: (c^2 << 32) / s^2, one quotient bit a cycle
    logic [DEN_W-1:0] rem_reg;
    logic [W_W-1:0]   q_reg;
    logic [DEN_W:0]   r2;
    logic             r2_ge;
    logic [DEN_W-1:0] c2_ext;
    logic             sat;

    assign c2_ext = DEN_W'(c2_reg);
    assign sat    = (den_reg == '0) || (c2_ext >= den_reg);
    assign r2     = {rem_reg, 1'b0};
    assign r2_ge  = (r2 >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= c2_ext;
            q_reg   <= sat ? '1 : '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= r2_ge ? DEN_W'(r2 - {1'b0, den_reg}) : r2[DEN_W-1:0];
            q_reg   <= {q_reg[W_W-2:0], r2_ge};
        end
    end

    // Weighted coordinates
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [7:0]        cx_sel;
    logic signed [7:0]        cy_sel;
    logic signed [PROD_W-1:0] w_signed;

    always_comb
    begin
        cx_sel = '0;
        cy_sel = '0;
        if (aid_reg < 2'd3)
        begin
            cx_sel = cx_reg[aid_reg];
            cy_sel = cy_reg[aid_reg];
        end
    end

    assign w_signed = $signed({{(PROD_W-W_W){1'b0}}, q_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            px_reg <= w_signed * PROD_W'(cx_sel);
            py_reg <= w_signed * PROD_W'(cy_sel);
        end
    end

    // Set accumulators
    logic [WT_W-1:0]        wt_reg;
    logic signed [WX_W-1:0] wx_reg;
    logic signed [WX_W-1:0] wy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_reg      <= '0;
            wx_reg      <= '0;
            wy_reg      <= '0;
            rc_reg      <= '0;
            invalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            wt_reg      <= '0;
            wx_reg      <= '0;
            wy_reg      <= '0;
            rc_reg      <= '0;
            invalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch && !aid_in_range)
            begin
                invalid_reg <= 1'b1;
            end
            if (cmd.acc)
            begin
                wt_reg <= wt_reg + WT_W'(q_reg);
                wx_reg <= wx_reg + WX_W'(px_reg);
                wy_reg <= wy_reg + WX_W'(py_reg);
                rc_reg <= rc_reg + 7'd1;
            end
        end
    end

    // Final divider: |total| / weight, 8 quotient bits, then restore sign
    logic [WT_W-1:0]        frem_reg;
    logic [7:0]             fsh_reg;
    logic [Q_W-1:0]         fq_reg;
    logic                   fneg_reg;
    logic [Q_W-1:0]         rx_reg;
    logic signed [WX_W-1:0] fsrc;
    logic [WX_W-1:0]        fmag;
    logic [WT_W:0]          fr2;
    logic                   fr2_ge;
    logic [Q_W-1:0]         fres;

    assign fsrc   = cmd.fin_y ? wy_reg : wx_reg;
    assign fmag   = fsrc[WX_W-1] ? WX_W'(-fsrc) : fsrc;
    assign fr2    = {frem_reg, fsh_reg[7]};
    assign fr2_ge = (fr2 >= {1'b0, wt_reg});
    assign fres   = fneg_reg ? Q_W'(-fq_reg) : fq_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fin_init)
        begin
            frem_reg <= fmag[WX_W-1:8];
            fsh_reg  <= fmag[7:0];
            fq_reg   <= '0;
            fneg_reg <= fsrc[WX_W-1];
            if (cmd.fin_y)
            begin
                rx_reg <= fres;
            end
        end
        else if (cmd.fin_step)
        begin
            frem_reg <= fr2_ge ? WT_W'(fr2 - {1'b0, wt_reg}) : fr2[WT_W-1:0];
            fsh_reg  <= {fsh_reg[6:0], 1'b0};
            fq_reg   <= {fq_reg[Q_W-2:0], fr2_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            step_reg <= sat ? '0 : STEP_W'(W_W);
        end
        else if (cmd.fin_init)
        begin
            step_reg <= STEP_W'(Q_W);
        end
        else if (cmd.div_step || cmd.fin_step)
        begin
            step_reg <= step_reg - 6'd1;
        end
    end

    // Output register
    logic       ovalid_reg;
    logic [7:0] ox_reg;
    logic [7:0] oy_reg;
    logic [1:0] ost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (wt_reg == '0)
            begin
                ox_reg  <= '0;
                oy_reg  <= '0;
                ost_reg <= rwc_pkg::STATUS_EMPTY;
            end
            else
            begin
                ox_reg  <= rx_reg;
                oy_reg  <= fres;
                ost_reg <= invalid_reg ? rwc_pkg::STATUS_INVALID : rwc_pkg::STATUS_OK;
            end
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_pos_x  = ox_reg;
    assign out_pos_y  = oy_reg;
    assign out_status = ost_reg;

    assign stat.item_ok   = ok_reg;
    assign stat.item_last = last_reg;
    assign stat.wt_zero   = (wt_reg == '0);
    assign stat.iter_done = (step_reg == '0);
    assign stat.out_free  = !ovalid_reg || out_ready;

endmodule
`default_nettype wire

// ----- rtl/rwc_checker.sv -----
// Port-level checks for rssi_weighted_centroid_top, attached by bind.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module rwc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // One report at a time: input closes right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // Status code 3 is never produced
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined status code");

    // Empty set reports the origin
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == 2'd2 |-> m_tdata == 16'd0)
        else $error("empty set with nonzero position");

endmodule

bind rssi_weighted_centroid_top rwc_checker u_rwc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
